// ----- hw/rtl/hwct_pkg.sv -----
// Shared types and constants for the hue window centroid tracker.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.

package hwct_pkg;

  localparam int unsigned CoordLimit = 2048;
  localparam int unsigned CoordMax   = CoordLimit - 1;

  localparam int unsigned CoordW  = 11;
  localparam int unsigned HueW    = 8;
  localparam int unsigned RadW    = 10;
  localparam int unsigned SizeW   = 12;
  localparam int unsigned SumW    = 34;
  localparam int unsigned CntW    = 23;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned WinW    = SizeW + 2;
  localparam int unsigned StepW   = 4;

  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 48;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef logic signed [WinW-1:0] hwct_win_t;

  typedef enum logic [KindW-1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_PLACE = 2'd2
  } hwct_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_RADIUS   = 3'd2,
    REG_IMG_W    = 3'd3,
    REG_IMG_H    = 3'd4
  } hwct_reg_e;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } hwct_bk_state_e;

  typedef struct packed {
    logic [HueW-1:0]  hue_low;
    logic [HueW-1:0]  hue_high;
    logic [RadW-1:0]  radius;
    logic [SizeW-1:0] img_w;
    logic [SizeW-1:0] img_h;
  } hwct_cfg_t;

  typedef struct packed {
    hwct_kind_e        kind;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              hue_hit;
  } hwct_op_t;

endpackage

// ----- hw/rtl/hwct_front.sv -----
// Front end: takes input words, saturates coordinates, checks the hue bounds
// and pushes one operation per useful word into the queue. Uses hwct_pkg.

module hwct_front (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hwct_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic [hwct_pkg::KindW-1:0]      s_axis_tuser,
  input  hwct_pkg::hwct_cfg_t             cfg_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output hwct_pkg::hwct_op_t              op_o
);

  logic [hwct_pkg::CoordW-1:0] col_raw;
  logic [hwct_pkg::CoordW-1:0] row_raw;
  logic [hwct_pkg::HueW-1:0]   hue;

  assign col_raw = s_axis_tdata[10:0];
  assign row_raw = s_axis_tdata[21:11];
  assign hue     = s_axis_tdata[29:22];

  assign s_axis_tready = !q_full_i;

  always_comb begin
    op_o.kind = hwct_pkg::hwct_kind_e'(s_axis_tuser);
    op_o.col  = (32'(col_raw) > hwct_pkg::CoordMax) ?
                hwct_pkg::CoordW'(hwct_pkg::CoordMax) : col_raw;
    op_o.row  = (32'(row_raw) > hwct_pkg::CoordMax) ?
                hwct_pkg::CoordW'(hwct_pkg::CoordMax) : row_raw;
    op_o.hue_hit = (hue > cfg_i.hue_low) && (hue < cfg_i.hue_high);
    push_o = 1'b0;
    case (hwct_pkg::hwct_kind_e'(s_axis_tuser))
      hwct_pkg::KIND_PIXEL,
      hwct_pkg::KIND_FRAME,
      hwct_pkg::KIND_PLACE: push_o = s_axis_tvalid && !q_full_i;
      // The reserved kind is accepted and dropped.
      default: push_o = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/hwct_queue.sv -----
// Short operation queue between the front end and the back end.
// Uses hwct_pkg for the entry type and depth.

module hwct_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hwct_pkg::hwct_op_t op_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output hwct_pkg::hwct_op_t head_o
);

  hwct_pkg::hwct_op_t          mem_q [hwct_pkg::QDepth];
  logic [hwct_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [hwct_pkg::QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [hwct_pkg::QPtrW:0]    cnt_q, cnt_d;
  logic                        do_pop;

  assign full_o       = (cnt_q == (hwct_pkg::QPtrW + 1)'(hwct_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ----- hw/rtl/hwct_div.sv -----
// Restoring divider with two lanes that share one divisor: column and row sums
// over the match count, one quotient bit per cycle. Uses hwct_pkg.

module hwct_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hwct_pkg::SumW-1:0]   col_sum_i,
  input  logic [hwct_pkg::SumW-1:0]   row_sum_i,
  input  logic [hwct_pkg::CntW-1:0]   count_i,
  output logic                        done_o,
  output logic [hwct_pkg::CoordW-1:0] q_col_o,
  output logic [hwct_pkg::CoordW-1:0] q_row_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [hwct_pkg::StepW-1:0]  step_q, step_d;
  logic [hwct_pkg::SumW-1:0]   dsh_q, dsh_d;
  logic [hwct_pkg::SumW-1:0]   rc_q, rc_d;
  logic [hwct_pkg::SumW-1:0]   rr_q, rr_d;
  logic [hwct_pkg::CoordW-1:0] qc_q, qc_d;
  logic [hwct_pkg::CoordW-1:0] qr_q, qr_d;

  assign done_o  = done_q;
  assign q_col_o = qc_q;
  assign q_row_o = qr_q;

  // Each sum is below count * CoordLimit, so the quotient fits in CoordW bits
  // and the divisor starts shifted up by CoordW - 1.
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    dsh_d  = dsh_q;
    rc_d   = rc_q;
    rr_d   = rr_q;
    qc_d   = qc_q;
    qr_d   = qr_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = hwct_pkg::StepW'(hwct_pkg::CoordW - 1);
      dsh_d  = hwct_pkg::SumW'(count_i) << (hwct_pkg::CoordW - 1);
      rc_d   = col_sum_i;
      rr_d   = row_sum_i;
      qc_d   = '0;
      qr_d   = '0;
    end else if (busy_q) begin
      if (rc_q >= dsh_q) begin
        rc_d = rc_q - dsh_q;
        qc_d = {qc_q[hwct_pkg::CoordW-2:0], 1'b1};
      end else begin
        qc_d = {qc_q[hwct_pkg::CoordW-2:0], 1'b0};
      end
      if (rr_q >= dsh_q) begin
        rr_d = rr_q - dsh_q;
        qr_d = {qr_q[hwct_pkg::CoordW-2:0], 1'b1};
      end else begin
        qr_d = {qr_q[hwct_pkg::CoordW-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsh_q <= dsh_d;
    rc_q  <= rc_d;
    rr_q  <= rr_d;
    qc_q  <= qc_d;
    qr_q  <= qr_d;
  end

endmodule

// ----- hw/rtl/hwct_back.sv -----
// Back end: window test and accumulation of pixels, centre placement, and the
// end-of-frame result, through the divider if any pixel matched, into the output register.
// Uses hwct_pkg and hwct_div.

module hwct_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hwct_pkg::hwct_cfg_t         cfg_i,
  input  logic                        head_valid_i,
  input  hwct_pkg::hwct_op_t          head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hwct_pkg::CoordW-1:0] out_col_o,
  output logic [hwct_pkg::CoordW-1:0] out_row_o,
  output logic                        out_found_o,
  output logic [hwct_pkg::CntW-1:0]   out_count_o
);

  hwct_pkg::hwct_bk_state_e    state_q, state_d;
  logic [hwct_pkg::CoordW-1:0] cx_q, cx_d;
  logic [hwct_pkg::CoordW-1:0] cy_q, cy_d;
  logic [hwct_pkg::SumW-1:0]   csum_q, csum_d;
  logic [hwct_pkg::SumW-1:0]   rsum_q, rsum_d;
  logic [hwct_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        ov_q, ov_d;
  logic [hwct_pkg::CoordW-1:0] ocol_q, ocol_d;
  logic [hwct_pkg::CoordW-1:0] orow_q, orow_d;
  logic                        ofound_q, ofound_d;
  logic [hwct_pkg::CntW-1:0]   ocnt_q, ocnt_d;

  logic                        out_free;
  logic                        div_start;
  logic                        div_done;
  logic [hwct_pkg::CoordW-1:0] div_qc;
  logic [hwct_pkg::CoordW-1:0] div_qr;
  logic [hwct_pkg::CoordW-1:0] half;
  logic                        pix_hit;

  // Inclusive start, exclusive end; the end is pulled to size - 1 and then to 0.
  function automatic logic win_hit(input logic [hwct_pkg::CoordW-1:0] pos,
                                   input logic [hwct_pkg::CoordW-1:0] centre,
                                   input logic [hwct_pkg::CoordW-1:0] hw,
                                   input logic [hwct_pkg::SizeW-1:0]  size);
    hwct_pkg::hwct_win_t lo;
    hwct_pkg::hwct_win_t hi;
    hwct_pkg::hwct_win_t sz;
    lo = hwct_pkg::hwct_win_t'(centre) - hwct_pkg::hwct_win_t'(hw);
    hi = hwct_pkg::hwct_win_t'(centre) + hwct_pkg::hwct_win_t'(hw);
    sz = hwct_pkg::hwct_win_t'(size);
    if (lo < 0) begin
      lo = '0;
    end
    if (hi >= sz) begin
      hi = sz - 1;
    end
    if (hi < 0) begin
      hi = '0;
    end
    return (hwct_pkg::hwct_win_t'(pos) >= lo) && (hwct_pkg::hwct_win_t'(pos) < hi);
  endfunction

  hwct_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .col_sum_i (csum_q),
    .row_sum_i (rsum_q),
    .count_i   (cnt_q),
    .done_o    (div_done),
    .q_col_o   (div_qc),
    .q_row_o   (div_qr)
  );

  assign half     = {cfg_i.radius, 1'b0};
  assign out_free = !ov_q || out_ready_i;
  assign pix_hit  = head_i.hue_hit && (cnt_q != hwct_pkg::CntMax) &&
                    win_hit(head_i.col, cx_q, half, cfg_i.img_w) &&
                    win_hit(head_i.row, cy_q, half, cfg_i.img_h);

  assign out_valid_o = ov_q;
  assign out_col_o   = ocol_q;
  assign out_row_o   = orow_q;
  assign out_found_o = ofound_q;
  assign out_count_o = ocnt_q;

  always_comb begin
    state_d   = state_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    csum_d    = csum_q;
    rsum_d    = rsum_q;
    cnt_d     = cnt_q;
    ov_d      = ov_q && !out_ready_i;
    ocol_d    = ocol_q;
    orow_d    = orow_q;
    ofound_d  = ofound_q;
    ocnt_d    = ocnt_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      hwct_pkg::BK_RUN: begin
        if (head_valid_i) begin
          case (head_i.kind)
            hwct_pkg::KIND_PIXEL: begin
              pop_o = 1'b1;
              if (pix_hit) begin
                csum_d = csum_q + hwct_pkg::SumW'(head_i.col);
                rsum_d = rsum_q + hwct_pkg::SumW'(head_i.row);
                cnt_d  = cnt_q + 1'b1;
              end
            end
            hwct_pkg::KIND_PLACE: begin
              pop_o = 1'b1;
              cx_d  = head_i.col;
              cy_d  = head_i.row;
            end
            hwct_pkg::KIND_FRAME: begin
              if (cnt_q == '0) begin
                // Empty frame: report the kept centre without dividing.
                if (out_free) begin
                  pop_o    = 1'b1;
                  ov_d     = 1'b1;
                  ocol_d   = cx_q;
                  orow_d   = cy_q;
                  ofound_d = 1'b0;
                  ocnt_d   = '0;
                  csum_d   = '0;
                  rsum_d   = '0;
                end
              end else begin
                pop_o     = 1'b1;
                div_start = 1'b1;
                state_d   = hwct_pkg::BK_DIV;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      hwct_pkg::BK_DIV: begin
        if (div_done && out_free) begin
          cx_d     = div_qc;
          cy_d     = div_qr;
          ov_d     = 1'b1;
          ocol_d   = div_qc;
          orow_d   = div_qr;
          ofound_d = 1'b1;
          ocnt_d   = cnt_q;
          csum_d   = '0;
          rsum_d   = '0;
          cnt_d    = '0;
          state_d  = hwct_pkg::BK_RUN;
        end
      end
      default: state_d = hwct_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hwct_pkg::BK_RUN;
      cx_q    <= '0;
      cy_q    <= '0;
      csum_q  <= '0;
      rsum_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      csum_q  <= csum_d;
      rsum_q  <= rsum_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ocol_q   <= ocol_d;
    orow_q   <= orow_d;
    ofound_q <= ofound_d;
    ocnt_q   <= ocnt_d;
  end

endmodule

// ----- hw/rtl/hue_window_centroid_tracker.sv -----
// Top level of the hue window centroid tracker: configuration registers and
// the front end, queue and back end. Uses hwct_pkg, hwct_front, hwct_queue, hwct_back.
//
// Usage:
//   The slave stream carries one word per pixel, end of frame or centre
//   placement (tuser holds the kind; kind 3 is taken and dropped). The master
//   stream carries one result word for every end of frame: the new or kept centre,
//   the match count, and tuser set when any pixel matched.
//   Pixels and placements are taken one per cycle while the queue has room; the
//   front end pushes them into a four-word queue and the back end retires one
//   per cycle while it is not waiting on the divider or the output register.
//   An end of frame with matches runs the two-lane divider, one quotient bit
//   per cycle, and holds the back end until the divider is done and the output
//   register is free; with no matches it reports the centre without dividing.
//   While the divider runs, the queue takes up to four more words before tready drops.
//   If the receiver stalls, the result waits in the output register; pixels
//   keep flowing, and only the next end of frame waits for the register.
//   Reset clears the centre, the sums and the queue, and loads the register defaults.
//   The user writes configuration only while the block is idle; it is not enforced.

module hue_window_centroid_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // col [10:0], row [21:11], hue [29:22], zero [31:30]
  input  logic [hwct_pkg::InTdataW-1:0]    s_axis_tdata,
  // kind [1:0]
  input  logic [hwct_pkg::KindW-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // centre_col [10:0], centre_row [21:11], match_count [44:22], zero [47:45]
  output logic [hwct_pkg::OutTdataW-1:0]   m_axis_tdata,
  // found [0]
  output logic                             m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [hwct_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [hwct_pkg::CfgW-1:0]        cfg_data_i
);

  hwct_pkg::hwct_cfg_t         cfg_q, cfg_d;
  hwct_pkg::hwct_op_t          push_op;
  hwct_pkg::hwct_op_t          head_op;
  logic                        push;
  logic                        q_full;
  logic                        head_valid;
  logic                        pop;
  logic [hwct_pkg::CoordW-1:0] out_col;
  logic [hwct_pkg::CoordW-1:0] out_row;
  logic [hwct_pkg::CntW-1:0]   out_count;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (hwct_pkg::hwct_reg_e'(cfg_idx_i))
        hwct_pkg::REG_HUE_LOW:  cfg_d.hue_low  = cfg_data_i[hwct_pkg::HueW-1:0];
        hwct_pkg::REG_HUE_HIGH: cfg_d.hue_high = cfg_data_i[hwct_pkg::HueW-1:0];
        hwct_pkg::REG_RADIUS:   cfg_d.radius   = cfg_data_i[hwct_pkg::RadW-1:0];
        hwct_pkg::REG_IMG_W:    cfg_d.img_w    = cfg_data_i[hwct_pkg::SizeW-1:0];
        hwct_pkg::REG_IMG_H:    cfg_d.img_h    = cfg_data_i[hwct_pkg::SizeW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= hwct_pkg::HueW'(0);
      cfg_q.hue_high <= hwct_pkg::HueW'(10);
      cfg_q.radius   <= hwct_pkg::RadW'(0);
      cfg_q.img_w    <= hwct_pkg::SizeW'(640);
      cfg_q.img_h    <= hwct_pkg::SizeW'(480);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hwct_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .op_o          (push_op)
  );

  hwct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .op_i         (push_op),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_op)
  );

  hwct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_op),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .out_found_o  (m_axis_tuser),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata = hwct_pkg::OutTdataW'({out_count, out_row, out_col});

endmodule
